// ----- hw/rtl/nec_pkg.sv -----
// Package for the NFA epsilon-closure block: operation codes, field widths
// and the controller state type. Used by the top level and its checker.
`default_nettype none

package nec_pkg;

    localparam int OP_W     = 3;
    localparam int VERTEX_W = 6;
    localparam int SYM_W    = 8;
    localparam int SET_W    = 64;
    // One bit wider than a vertex number, so that a bound of 64 still fits.
    localparam int VCMP_W   = VERTEX_W + 1;

    localparam logic [OP_W-1:0] OP_ADD_EDGE     = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_VERTEX  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE_VERTEX = 3'd2;
    localparam logic [OP_W-1:0] OP_CLOSE_SET    = 3'd3;
    localparam logic [OP_W-1:0] OP_MARK_SET     = 3'd4;

    localparam logic [SYM_W-1:0] EPSILON_SYMBOL = 8'd101;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE,
        S_CLOSE
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/nfa_epsilon_closure.sv -----
// NFA epsilon-closure engine: top level with adjacency RAM and closure walker.
// Depends on nec_pkg and nec_ram.
//
// Usage
//   Input channel: i_valid / o_stall with fields i_op, i_src_vertex, i_symbol,
//   i_dst_vertex and i_vertex_set. A word is taken at a rising edge with
//   i_valid high and o_stall low. Output channel: o_valid / i_stall with
//   o_closure_set and o_has_final; only closure queries produce a word.
//   Operation
//   Mark-final words need no RAM access and leave the block idle. An epsilon
//   edge reads its adjacency row from the RAM and writes it back with the new
//   bit. A closure query reads one adjacency row per vertex it reaches, then
//   sees that nothing is left pending and writes its result when the output
//   register is free. The single RAM read port allows one row read at a time.
//   The result is registered; the next word is accepted while it waits.
//   Reset
//   Reset empties the graph and the final mask at once: each adjacency row
//   carries a valid flag and reads as zero until first written.
//   Stall
//   A held result keeps its value; a closure that finishes meanwhile waits
//   in the walker and o_stall stays high until the output register frees.
`default_nettype none

module nfa_epsilon_closure
    import nec_pkg::*;
#(
    parameter int NUM_VERTICES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [VERTEX_W-1:0] i_src_vertex,
    input  wire logic [SYM_W-1:0]    i_symbol,
    input  wire logic [VERTEX_W-1:0] i_dst_vertex,
    input  wire logic [SET_W-1:0]    i_vertex_set,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [SET_W-1:0]         o_closure_set,
    output logic                     o_has_final
);

    localparam int NV = NUM_VERTICES;
    localparam int AW = $clog2(NV);

    t_state          r_state, n_state;
    logic [NV-1:0]   r_reached, n_reached;
    logic [NV-1:0]   r_pending, n_pending;
    logic [NV-1:0]   r_extra, n_extra;
    logic            r_inflight, n_inflight;
    logic [NV-1:0]   r_row_valid, n_row_valid;
    logic [NV-1:0]   r_final, n_final;
    logic [AW-1:0]   r_src_idx, n_src_idx;
    logic [AW-1:0]   r_dst_idx, n_dst_idx;
    logic            r_rd_ok;
    logic            r_out_valid, n_out_valid;
    logic [NV-1:0]   r_out_set, n_out_set;
    logic            r_out_final, n_out_final;

    logic            accept;
    logic            src_ok, dst_ok;
    logic [AW-1:0]   src_idx, dst_idx;
    logic [NV-1:0]   in_set;
    logic [NV-1:0]   row_data, fresh, cand, pick_onehot;
    logic [AW-1:0]   pick_idx;
    logic            out_free;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [NV-1:0]   ram_wdata, ram_rdata;

    nec_ram #(
        .WIDTH(NV),
        .DEPTH(NV)
    ) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign accept        = i_valid && !o_stall;
    assign src_ok        = {1'b0, i_src_vertex} < VCMP_W'(NV);
    assign dst_ok        = {1'b0, i_dst_vertex} < VCMP_W'(NV);
    assign src_idx       = i_src_vertex[AW-1:0];
    assign dst_idx       = i_dst_vertex[AW-1:0];
    assign in_set        = i_vertex_set[NV-1:0];
    assign row_data      = r_rd_ok ? ram_rdata : '0;
    assign out_free      = !r_out_valid || !i_stall;
    assign o_valid       = r_out_valid;
    assign o_closure_set = SET_W'(r_out_set);
    assign o_has_final   = r_out_final;

    // Lowest pending vertex is visited next; the visiting order does not
    // change the closure.
    assign fresh       = r_inflight ? (row_data & ~r_reached) : '0;
    assign cand        = r_pending | fresh;
    assign pick_onehot = cand & (~cand + NV'(1));

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < NV; i++) begin
            if (pick_onehot[i]) begin
                pick_idx = pick_idx | AW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_reached   = r_reached;
        n_pending   = r_pending;
        n_extra     = r_extra;
        n_inflight  = r_inflight;
        n_row_valid = r_row_valid;
        n_final     = r_final;
        n_src_idx   = r_src_idx;
        n_dst_idx   = r_dst_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out_set   = r_out_set;
        n_out_final = r_out_final;
        ram_we      = 1'b0;
        ram_waddr   = r_src_idx;
        ram_wdata   = row_data | (NV'(1) << r_dst_idx);
        ram_raddr   = src_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_src_idx = src_idx;
                    n_dst_idx = dst_idx;
                    unique case (i_op)
                        OP_ADD_EDGE: begin
                            if (i_symbol == EPSILON_SYMBOL && src_ok && dst_ok) begin
                                n_state = S_EDGE;
                            end
                        end
                        OP_MARK_VERTEX: begin
                            if (src_ok) begin
                                n_final = r_final | (NV'(1) << src_idx);
                            end
                        end
                        OP_MARK_SET: begin
                            n_final = r_final | in_set;
                        end
                        OP_CLOSE_VERTEX: begin
                            n_reached  = src_ok ? (NV'(1) << src_idx) : '0;
                            n_pending  = src_ok ? (NV'(1) << src_idx) : '0;
                            n_extra    = in_set;
                            n_inflight = 1'b0;
                            n_state    = S_CLOSE;
                        end
                        OP_CLOSE_SET: begin
                            n_reached  = in_set;
                            n_pending  = in_set;
                            n_extra    = '0;
                            n_inflight = 1'b0;
                            n_state    = S_CLOSE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE: begin
                // The row read at accept is now on the RAM output.
                ram_we                 = 1'b1;
                n_row_valid[r_src_idx] = 1'b1;
                n_state                = S_IDLE;
            end
            S_CLOSE: begin
                n_reached = r_reached | fresh;
                if (cand != '0) begin
                    n_pending  = cand & ~pick_onehot;
                    ram_raddr  = pick_idx;
                    n_inflight = 1'b1;
                end else begin
                    n_pending  = '0;
                    n_inflight = 1'b0;
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_set   = n_reached | r_extra;
                        n_out_final = |((n_reached | r_extra) & r_final);
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inflight  <= 1'b0;
            r_row_valid <= '0;
            r_final     <= '0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inflight  <= n_inflight;
            r_row_valid <= n_row_valid;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
            r_rd_ok     <= r_row_valid[ram_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_reached   <= n_reached;
        r_pending   <= n_pending;
        r_extra     <= n_extra;
        r_src_idx   <= n_src_idx;
        r_dst_idx   <= n_dst_idx;
        r_out_set   <= n_out_set;
        r_out_final <= n_out_final;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nec_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module nec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nec_checker.sv -----
// Port-level checks for the NFA epsilon-closure block, bound to its top level.
// Depends on nec_pkg.
`default_nettype none

module nec_checker
    import nec_pkg::*;
#(
    parameter int NUM_VERTICES = 64
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic [OP_W-1:0]     i_op,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [SET_W-1:0]    o_closure_set,
    input wire logic                o_has_final
);

    // A held result word keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_closure_set) && $stable(o_has_final))
        else $error("result word changed while stalled");

    // No vertex beyond the configured count ever appears in a closure.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_closure_set >> NUM_VERTICES) == '0))
        else $error("closure holds a vertex out of range");

    // Marking final needs no RAM access, so the block is free at once.
    a_mark_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_MARK_VERTEX || i_op == OP_MARK_SET)
        |=> !o_stall)
        else $error("mark word left the block busy");

    // A new result only comes out of a closure walk, which keeps the block busy.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result word without a closure walk");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

endmodule

bind nfa_epsilon_closure nec_checker #(
    .NUM_VERTICES(NUM_VERTICES)
) u_nec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_closure_set(o_closure_set),
    .o_has_final  (o_has_final)
);

`default_nettype wire
